// ===== hw/rtl/ctc_pkg.sv =====
`default_nettype none

package ctc_pkg;

    localparam int MAX_COLUMNS = 8;
    localparam int MAX_TEXT    = 64;

    localparam int KEY_W   = 64;
    localparam int KLEN_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CNT_W   = $clog2(MAX_TEXT + 1);
    localparam int ADDR_W  = $clog2(MAX_TEXT);
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h71;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LETTERS = 2'd0,
        CFG_KEY_LENGTH  = 2'd1,
        CFG_DIRECTION   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_in;
    } ctc_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_out;
        logic              overflow;
    } ctc_out_t;

    // out-of-range key lengths clamp to 1..MAX_COLUMNS
    function automatic logic [KLEN_W-1:0] eff_columns(input logic [KLEN_W-1:0] len);
        logic [KLEN_W-1:0] k;
        k = len;
        if (len == '0) begin
            k = KLEN_W'(1);
        end else if (len > KLEN_W'(MAX_COLUMNS)) begin
            k = KLEN_W'(MAX_COLUMNS);
        end
        return k;
    endfunction

    // byte count of the largest whole number of rows that fits the buffer
    function automatic logic [CNT_W-1:0] cap_for(input logic [KLEN_W-1:0] k);
        logic [CNT_W-1:0] cap;
        cap = CNT_W'(MAX_TEXT);
        for (int i = 1; i <= MAX_COLUMNS; i++) begin
            if (k == KLEN_W'(i)) begin
                // step up through multiples of i while they still fit
                for (int m = i; m <= MAX_TEXT; m += i) begin
                    cap = CNT_W'(m);
                end
            end
        end
        return cap;
    endfunction

    function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
                                                   input logic [COL_W-1:0] idx);
        return key[BYTE_W*idx +: BYTE_W];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/columnar_transposition_cipher.sv =====
`default_nettype none

// Keyed columnar transposition over messages of up to 64 bytes. Bytes are taken one per
// cycle into a buffer RAM; overflow past the largest whole number of key-length rows is
// dropped and reported on every output byte of that message. After the byte marked last,
// the block is busy (s_ready low): it ranks the columns through a single byte comparator,
// finds the row count by repeated addition, then streams the output one byte per cycle
// while m_ready is high, read through the single RAM read port at addresses formed by the
// shared multiply-add. Configuration must be written by the user only while no message is
// in flight; the block itself does not enforce this. cfg_ready is always high.
module columnar_transposition_cipher (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire ctc_pkg::ctc_in_t                  s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output ctc_pkg::ctc_out_t                      m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ctc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ctc_pkg::KEY_W-1:0]         cfg_data
);
    import ctc_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_RANK = 5'b00010,
        ST_ROWS = 5'b00100,
        ST_READ = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KLEN_W-1:0] klen_reg, klen_next;
    logic              dir_reg, dir_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              drop_reg, drop_next;

    logic [COL_W-1:0]  rank_reg [MAX_COLUMNS];
    logic [COL_W-1:0]  rank_next [MAX_COLUMNS];
    logic [COL_W-1:0]  order_reg [MAX_COLUMNS];
    logic [COL_W-1:0]  order_next [MAX_COLUMNS];
    logic [COL_W-1:0]  rc_reg, rc_next;
    logic [COL_W-1:0]  rj_reg, rj_next;
    logic [COL_W-1:0]  racc_reg, racc_next;

    logic [CNT_W-1:0]  rows_reg, rows_next;
    logic [CNT_W:0]    acc_reg, acc_next;

    logic [CNT_W-1:0]  outer_reg, outer_next;
    logic [CNT_W-1:0]  inner_reg, inner_next;
    logic              pad_reg, pad_next;
    logic              last_reg, last_next;

    logic [KLEN_W-1:0]   k_eff;
    logic                in_xfer;
    logic                ram_we;
    logic [BYTE_W-1:0]   kj, kc;
    logic                rank_inc;
    logic [COL_W-1:0]    rsum;
    logic                j_last, c_last;
    logic [CNT_W-1:0]    ilim, olim;
    logic [CNT_W-1:0]    mul_a, mul_b, addend;
    logic [2*CNT_W-1:0]  pos;
    logic                pos_pad;
    logic                pos_last;
    logic                read_fire;
    logic [BYTE_W-1:0]   ram_rdata;

    assign k_eff     = eff_columns(klen_reg);
    assign s_ready   = (state_reg == ST_LOAD);
    assign in_xfer   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign ram_we    = in_xfer && (count_reg < cap_for(k_eff));

    // column ranking: one key-byte compare per cycle
    assign kj       = key_byte(key_reg, rj_reg);
    assign kc       = key_byte(key_reg, rc_reg);
    assign rank_inc = (kj < kc) || ((kj == kc) && (rj_reg < rc_reg));
    assign rsum     = racc_reg + COL_W'(rank_inc);
    assign j_last   = (KLEN_W'(rj_reg) == k_eff - KLEN_W'(1));
    assign c_last   = (KLEN_W'(rc_reg) == k_eff - KLEN_W'(1));

    // shared multiply-add: encrypt i*k + order[r], decrypt rank[col]*rows + row
    assign ilim   = dir_reg ? CNT_W'(k_eff) : rows_reg;
    assign olim   = dir_reg ? rows_reg : CNT_W'(k_eff);
    assign mul_a  = dir_reg ? CNT_W'(rank_reg[inner_reg[COL_W-1:0]]) : inner_reg;
    assign mul_b  = dir_reg ? rows_reg : CNT_W'(k_eff);
    assign addend = dir_reg ? outer_reg : CNT_W'(order_reg[outer_reg[COL_W-1:0]]);
    assign pos    = mul_a * mul_b + (2*CNT_W)'(addend);
    assign pos_pad  = (pos >= (2*CNT_W)'(count_reg));
    assign pos_last = (inner_reg == ilim - CNT_W'(1)) && (outer_reg == olim - CNT_W'(1));

    assign read_fire = (state_reg == ST_READ)
                    || ((state_reg == ST_OUT) && m_ready && !last_reg);

    ctc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_data.text_byte),
        .re    (read_fire && !pos_pad),
        .raddr (pos[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        m_data.out_byte = pad_reg ? PAD_BYTE : ram_rdata;
        m_data.last_out = last_reg;
        m_data.overflow = drop_reg;
    end

    always_comb begin
        key_next   = key_reg;
        klen_next  = klen_reg;
        dir_next   = dir_reg;
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        rank_next  = rank_reg;
        order_next = order_reg;
        rc_next    = rc_reg;
        rj_next    = rj_reg;
        racc_next  = racc_reg;
        rows_next  = rows_reg;
        acc_next   = acc_reg;
        outer_next = outer_reg;
        inner_next = inner_reg;
        pad_next   = pad_reg;
        last_next  = last_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEY_LETTERS: key_next  = cfg_data;
                CFG_KEY_LENGTH:  klen_next = cfg_data[KLEN_W-1:0];
                CFG_DIRECTION:   dir_next  = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    if (ram_we) begin
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (s_data.last_in) begin
                        rc_next    = '0;
                        rj_next    = '0;
                        racc_next  = '0;
                        state_next = ST_RANK;
                    end
                end
            end
            ST_RANK: begin
                if (j_last) begin
                    rank_next[rc_reg] = rsum;
                    order_next[rsum]  = rc_reg;
                    racc_next         = '0;
                    rj_next           = '0;
                    rc_next           = rc_reg + COL_W'(1);
                    if (c_last) begin
                        rows_next  = '0;
                        acc_next   = '0;
                        state_next = ST_ROWS;
                    end
                end else begin
                    racc_next = rsum;
                    rj_next   = rj_reg + COL_W'(1);
                end
            end
            ST_ROWS: begin
                // rows = ceil(n / k) by repeated addition
                if (acc_reg < (CNT_W+1)'(count_reg)) begin
                    acc_next  = acc_reg + (CNT_W+1)'(k_eff);
                    rows_next = rows_reg + CNT_W'(1);
                end else begin
                    outer_next = '0;
                    inner_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready && last_reg) begin
                    count_next = '0;
                    drop_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (read_fire) begin
            pad_next  = pos_pad;
            last_next = pos_last;
            if (inner_reg == ilim - CNT_W'(1)) begin
                inner_next = '0;
                outer_next = outer_reg + CNT_W'(1);
            end else begin
                inner_next = inner_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            key_reg   <= '0;
            klen_reg  <= KLEN_W'(1);
            dir_reg   <= 1'b0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            key_reg   <= key_next;
            klen_reg  <= klen_next;
            dir_reg   <= dir_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        rank_reg  <= rank_next;
        order_reg <= order_next;
        rc_reg    <= rc_next;
        rj_reg    <= rj_next;
        racc_reg  <= racc_next;
        rows_reg  <= rows_next;
        acc_reg   <= acc_next;
        outer_reg <= outer_next;
        inner_reg <= inner_next;
        pad_reg   <= pad_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ctc_ram.sv =====
`default_nettype none

module ctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
